// ===== hdl/tdt_pkg.sv =====
// Shared types, codes and helpers for the tile damage tracker.
package tdt_pkg;

  // Cell geometry
  localparam int CELL_SHIFT   = 4;
  localparam int CELL_SIZE    = 1 << CELL_SHIFT;
  localparam int NUM_COLS     = 16;
  localparam int NUM_ROWS     = 16;
  localparam int ROW_W        = $clog2(NUM_ROWS);
  localparam int COL_W        = $clog2(NUM_COLS);
  localparam int POS_W        = COL_W + 1;
  localparam int CNT_W        = $clog2(NUM_ROWS * NUM_COLS / 2) + 1;
  localparam int DIM_W        = 9;
  localparam int CAP_W        = 7;
  localparam int RESULT_LIMIT = 64;
  localparam logic [DIM_W-1:0] SCENE_W_MAX = DIM_W'(NUM_COLS * CELL_SIZE);
  localparam logic [DIM_W-1:0] SCENE_H_MAX = DIM_W'(NUM_ROWS * CELL_SIZE);

  // Commands
  localparam logic [1:0] CMD_MARK    = 2'd0;
  localparam logic [1:0] CMD_ALL     = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;
  localparam logic [1:0] CMD_COLLECT = 2'd3;

  // Result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_CAP     = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_SCENE_W  = 2'd0;
  localparam logic [1:0] CFG_SCENE_H  = 2'd1;
  localparam logic [1:0] CFG_CAPACITY = 2'd2;

  // Result kinds loaded into the output register
  localparam logic [1:0] RES_PLAIN = 2'd0;
  localparam logic [1:0] RES_FULL  = 2'd1;
  localparam logic [1:0] RES_RUN   = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [15:0]        rect_width;
    logic [15:0]        rect_height;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             has_rect;
    logic [7:0]       out_x;
    logic [7:0]       out_y;
    logic [DIM_W-1:0] out_width;
    logic [DIM_W-1:0] out_height;
    logic             full_res;
    logic             pending;
    logic             last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch_in;
    logic       do_mark;
    logic       do_all;
    logic       do_clear;
    logic       ld_res;
    logic [1:0] res_sel;
    logic [1:0] res_status;
    logic       res_last;
    logic       scan_init;
    logic       scan_step;
    logic       walk_init;
    logic       walk_next;
    logic       walk_emit;
  } tdt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       size_zero;
    logic       any;
    logic       all_dirty;
    logic       cap_zero;
    logic       row_last;
    logic       over_cap;
    logic       work_zero;
    logic       run_last;
  } tdt_stat_t;

  // Index of the lowest set bit, or 16 when none is set
  function automatic logic [POS_W-1:0] low_one(input logic [NUM_COLS:0] v);
    logic [POS_W-1:0] pos;
    pos = POS_W'(NUM_COLS);
    for (int i = NUM_COLS; i >= 0; i--) begin
      if (v[i]) pos = POS_W'(i);
    end
    return pos;
  endfunction

  // Number of runs of ones in a row word
  function automatic logic [COL_W-1:0] run_count(input logic [NUM_COLS-1:0] w);
    logic [NUM_COLS-1:0] starts;
    starts = w & ~{w[NUM_COLS-2:0], 1'b0};
    return COL_W'($countones(starts));
  endfunction

endpackage

// ===== hdl/tile_damage_tracker_unit.sv =====
// Mark, mark-all, clear and the one-result collects (nothing dirty, zero capacity,
// whole-screen flag) load their result in the execute state.
// Collect over cell damage: a row count pass over every row, then a decision state; the
// full-scene fallback loads from the decision state, else the walk state loads runs one per
// cycle while the output is free, stepping past rows with no runs left. Output stalls hold
// each load back. One item at a time, the next taken the cycle after the last result loads.
// Reset (rst_n, synchronous): clears the cell map and flags, registers to 256/256/64.
module tile_damage_tracker_unit
  import tdt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  tdt_cmd_t  cmd;
  tdt_stat_t stat;

  tdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tdt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

  // One item at a time: busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item taken while previous item still in work");

  // Fallback rectangle is always a rectangle
  a_full_has_rect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.full_res) |-> out_item.has_rect)
    else $error("full-scene result without rectangle");

  // Error results are single, rectangle-free results
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> (!out_item.has_rect && out_item.last))
    else $error("error result carries rectangle or is not last");

  // Collected rectangles leave no damage pending
  a_rect_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.has_rect) |-> !out_item.pending)
    else $error("rectangle result reports pending damage");

endmodule

// ===== hdl/tdt_ctrl.sv =====
// Sequencing state machine for the tile damage tracker.
module tdt_ctrl
  import tdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output logic      cfg_ready,
  input  tdt_stat_t stat,
  output tdt_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_COUNT  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd)
          CMD_MARK: begin
            if (out_free) begin
              cmd.ld_res     = 1'b1;
              cmd.res_sel    = RES_PLAIN;
              cmd.res_status = stat.size_zero ? ST_INVALID : ST_OK;
              cmd.do_mark    = !stat.size_zero;
              state_nxt      = S_IDLE;
            end
          end
          CMD_ALL: begin
            if (out_free) begin
              cmd.ld_res  = 1'b1;
              cmd.res_sel = RES_PLAIN;
              cmd.do_all  = 1'b1;
              state_nxt   = S_IDLE;
            end
          end
          CMD_CLEAR: begin
            if (out_free) begin
              cmd.ld_res   = 1'b1;
              cmd.res_sel  = RES_PLAIN;
              cmd.do_clear = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          default: begin
            // collect: dispose of the one-result cases here
            priority if (!stat.any) begin
              if (out_free) begin
                cmd.ld_res  = 1'b1;
                cmd.res_sel = RES_PLAIN;
                state_nxt   = S_IDLE;
              end
            end else if (stat.cap_zero) begin
              if (out_free) begin
                cmd.ld_res     = 1'b1;
                cmd.res_sel    = RES_PLAIN;
                cmd.res_status = ST_CAP;
                state_nxt      = S_IDLE;
              end
            end else if (stat.all_dirty) begin
              if (out_free) begin
                cmd.ld_res   = 1'b1;
                cmd.res_sel  = RES_FULL;
                cmd.do_clear = 1'b1;
                state_nxt    = S_IDLE;
              end
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_COUNT;
            end
          end
        endcase
      end
      S_COUNT: begin
        cmd.scan_step = 1'b1;
        if (stat.row_last) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.over_cap) begin
          if (out_free) begin
            cmd.ld_res   = 1'b1;
            cmd.res_sel  = RES_FULL;
            cmd.do_clear = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.work_zero) begin
          cmd.walk_next = 1'b1;
        end else if (out_free) begin
          cmd.ld_res    = 1'b1;
          cmd.res_sel   = RES_RUN;
          cmd.res_last  = stat.run_last;
          cmd.walk_emit = 1'b1;
          if (stat.run_last) begin
            cmd.do_clear = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on load, dropped once taken
  always_comb begin
    if (cmd.ld_res) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/tdt_datapath.sv =====
// Cell map, configuration, clipping, run walk and result register.
module tdt_datapath
  import tdt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  input  tdt_cmd_t         cmd,
  output tdt_stat_t        stat,
  output out_item_t        out_item
);

  logic [NUM_COLS-1:0] rows_r [NUM_ROWS];
  logic                all_dirty_r;
  logic                any_r, any_nxt;
  logic [DIM_W-1:0]    scene_w_r, scene_h_r;
  logic [CAP_W-1:0]    capacity_r;
  in_item_t            item_r;
  out_item_t           res_r, res_nxt;

  logic [ROW_W-1:0]    row_ctr_r;
  logic [CNT_W-1:0]    run_cnt_r;
  logic [NUM_COLS-1:0] work_r;
  logic [CAP_W-1:0]    emitted_r;

  // Effective scene size and capacity
  logic [DIM_W-1:0] eff_w, eff_h;
  logic [CAP_W-1:0] cap_eff;

  always_comb begin
    priority if (scene_w_r == '0) eff_w = DIM_W'(1);
    else if (scene_w_r > SCENE_W_MAX) eff_w = SCENE_W_MAX;
    else eff_w = scene_w_r;
    priority if (scene_h_r == '0) eff_h = DIM_W'(1);
    else if (scene_h_r > SCENE_H_MAX) eff_h = SCENE_H_MAX;
    else eff_h = scene_h_r;
    cap_eff = (capacity_r > CAP_W'(RESULT_LIMIT)) ? CAP_W'(RESULT_LIMIT) : capacity_r;
  end

  // Rectangle clipping against the scene
  logic signed [17:0] left, top, right_raw, bottom_raw, right_c, bottom_c;
  logic signed [17:0] right_m1, bottom_m1;
  logic               mark_hit;
  logic [COL_W-1:0]   c0, c1;
  logic [ROW_W-1:0]   r0, r1;
  logic [NUM_COLS-1:0] col_mask;
  logic [NUM_ROWS-1:0] row_sel;

  always_comb begin
    left       = item_r.rect_x[15] ? 18'sd0 : 18'(item_r.rect_x);
    top        = item_r.rect_y[15] ? 18'sd0 : 18'(item_r.rect_y);
    right_raw  = 18'(item_r.rect_x) + $signed({2'b00, item_r.rect_width});
    bottom_raw = 18'(item_r.rect_y) + $signed({2'b00, item_r.rect_height});
    right_c    = (right_raw > $signed({9'd0, eff_w})) ? $signed({9'd0, eff_w}) : right_raw;
    bottom_c   = (bottom_raw > $signed({9'd0, eff_h})) ? $signed({9'd0, eff_h}) : bottom_raw;
    mark_hit   = (right_c > left) && (bottom_c > top);
    right_m1   = right_c - 18'sd1;
    bottom_m1  = bottom_c - 18'sd1;
    c0 = left[CELL_SHIFT +: COL_W];
    c1 = right_m1[CELL_SHIFT +: COL_W];
    r0 = top[CELL_SHIFT +: ROW_W];
    r1 = bottom_m1[CELL_SHIFT +: ROW_W];
    for (int c = 0; c < NUM_COLS; c++) begin
      col_mask[c] = (COL_W'(c) >= c0) && (COL_W'(c) <= c1);
    end
    for (int r = 0; r < NUM_ROWS; r++) begin
      row_sel[r] = (ROW_W'(r) >= r0) && (ROW_W'(r) <= r1);
    end
  end

  // Run extraction from the working row word
  logic [NUM_COLS-1:0] low_bit;
  logic [NUM_COLS:0]   run_sum;
  logic [POS_W-1:0]    first_pos, end_pos;
  logic [DIM_W-1:0]    run_left, run_right, run_top, run_bottom;

  always_comb begin
    low_bit    = work_r & (~work_r + NUM_COLS'(1));
    run_sum    = {1'b0, work_r} + {1'b0, low_bit};
    first_pos  = low_one({1'b0, work_r});
    end_pos    = low_one(run_sum);
    run_left   = {first_pos, {CELL_SHIFT{1'b0}}};
    run_right  = {end_pos, {CELL_SHIFT{1'b0}}};
    if (run_right > eff_w) run_right = eff_w;
    run_top    = {1'b0, row_ctr_r, {CELL_SHIFT{1'b0}}};
    run_bottom = {({1'b0, row_ctr_r} + (ROW_W + 1)'(1)), {CELL_SHIFT{1'b0}}};
    if (run_bottom > eff_h) run_bottom = eff_h;
  end

  // Damage flag after this cycle
  logic clear_map;
  assign clear_map = cmd.do_clear ||
                     (cfg_we && (cfg_index == CFG_SCENE_W || cfg_index == CFG_SCENE_H));
  assign any_nxt   = clear_map ? 1'b0 : (any_r || cmd.do_all || (cmd.do_mark && mark_hit));

  // Next result item by kind
  always_comb begin
    res_nxt = '0;
    unique case (cmd.res_sel)
      RES_FULL: begin
        res_nxt.has_rect   = 1'b1;
        res_nxt.out_width  = eff_w;
        res_nxt.out_height = eff_h;
        res_nxt.full_res   = 1'b1;
        res_nxt.last       = 1'b1;
      end
      RES_RUN: begin
        res_nxt.has_rect   = 1'b1;
        res_nxt.out_x      = run_left[7:0];
        res_nxt.out_y      = run_top[7:0];
        res_nxt.out_width  = run_right - run_left;
        res_nxt.out_height = run_bottom - run_top;
        res_nxt.last       = cmd.res_last;
      end
      default: begin
        res_nxt.status  = cmd.res_status;
        res_nxt.pending = any_nxt;
        res_nxt.last    = 1'b1;
      end
    endcase
  end

  // Map and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_ROWS; r++) rows_r[r] <= '0;
      all_dirty_r <= 1'b0;
      any_r       <= 1'b0;
      scene_w_r   <= SCENE_W_MAX;
      scene_h_r   <= SCENE_H_MAX;
      capacity_r  <= CAP_W'(RESULT_LIMIT);
    end else begin
      any_r <= any_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SCENE_W:  scene_w_r  <= cfg_data;
          CFG_SCENE_H:  scene_h_r  <= cfg_data;
          CFG_CAPACITY: capacity_r <= cfg_data[CAP_W-1:0];
          default: ;
        endcase
      end
      if (clear_map) begin
        for (int r = 0; r < NUM_ROWS; r++) rows_r[r] <= '0;
        all_dirty_r <= 1'b0;
      end else begin
        if (cmd.do_all) all_dirty_r <= 1'b1;
        if (cmd.do_mark && mark_hit) begin
          for (int r = 0; r < NUM_ROWS; r++) begin
            if (row_sel[r]) rows_r[r] <= rows_r[r] | col_mask;
          end
        end
      end
    end
  end

  // Item latch, scan counters and result register
  always_ff @(posedge clk) begin
    if (cmd.latch_in) item_r <= in_item;
    if (cmd.scan_init) begin
      row_ctr_r <= '0;
      run_cnt_r <= '0;
    end
    if (cmd.scan_step) begin
      run_cnt_r <= run_cnt_r + CNT_W'(run_count(rows_r[row_ctr_r]));
      row_ctr_r <= row_ctr_r + ROW_W'(1);
    end
    if (cmd.walk_init) begin
      row_ctr_r <= '0;
      work_r    <= rows_r[0];
      emitted_r <= '0;
    end
    if (cmd.walk_next) begin
      row_ctr_r <= row_ctr_r + ROW_W'(1);
      work_r    <= rows_r[row_ctr_r + ROW_W'(1)];
    end
    if (cmd.walk_emit) begin
      work_r    <= work_r & run_sum[NUM_COLS-1:0];
      emitted_r <= emitted_r + CAP_W'(1);
    end
    if (cmd.ld_res) res_r <= res_nxt;
  end

  assign out_item = res_r;

  // Status to the controller
  always_comb begin
    stat.cmd       = item_r.cmd;
    stat.size_zero = (item_r.rect_width == '0) || (item_r.rect_height == '0);
    stat.any       = any_r;
    stat.all_dirty = all_dirty_r;
    stat.cap_zero  = (cap_eff == '0);
    stat.row_last  = (row_ctr_r == ROW_W'(NUM_ROWS - 1));
    stat.over_cap  = (run_cnt_r > CNT_W'(cap_eff));
    stat.work_zero = (work_r == '0);
    stat.run_last  = ((CNT_W'(emitted_r) + CNT_W'(1)) == run_cnt_r);
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the tile damage tracker: predicts every result item and compares.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tdt_pkg::*;

  // Register index with no register behind it; writes must be dropped
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 52;
  localparam int FIXED_PHASES = 6;
  localparam int RANDOM_PHASES = 2;

  // Shadow of the tracker: cell map, flags, registers and the results still owed
  class damage_ledger;
    logic [NUM_COLS-1:0] dirty_rows [NUM_ROWS];
    bit                  whole_screen;
    logic [DIM_W-1:0]    scene_w;
    logic [DIM_W-1:0]    scene_h;
    logic [CAP_W-1:0]    capacity;
    out_item_t           expected_reports [$];
    int                  errors;
    int                  seen;

    function new();
      scene_w  = SCENE_W_MAX;
      scene_h  = SCENE_H_MAX;
      capacity = CAP_W'(RESULT_LIMIT);
      errors   = 0;
      seen     = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (dirty_rows[r]) dirty_rows[r] = '0;
      whole_screen = 1'b0;
    endfunction

    // Zero counts as one pixel, oversize saturates at the grid edge
    function int unsigned clip_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] top);
      if (v == '0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function int unsigned width_px();
      return clip_dim(scene_w, SCENE_W_MAX);
    endfunction

    function int unsigned height_px();
      return clip_dim(scene_h, SCENE_H_MAX);
    endfunction

    function bit any_dirty();
      if (whole_screen) return 1'b1;
      foreach (dirty_rows[r]) if (dirty_rows[r] != '0) return 1'b1;
      return 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        CFG_SCENE_W: begin
          scene_w = data;
          wipe();
        end
        CFG_SCENE_H: begin
          scene_h = data;
          wipe();
        end
        CFG_CAPACITY: capacity = data[CAP_W-1:0];
        default: ;
      endcase
    endfunction

    // Clip the signed rectangle to the scene and set every touched cell
    function void mark_area(in_item_t it);
      int x, y, lft, tp, rgt, btm;
      x   = $signed(it.rect_x);
      y   = $signed(it.rect_y);
      lft = x < 0 ? 0 : x;
      tp  = y < 0 ? 0 : y;
      rgt = x + int'(it.rect_width);
      btm = y + int'(it.rect_height);
      if (rgt > int'(width_px())) rgt = width_px();
      if (btm > int'(height_px())) btm = height_px();
      if (rgt <= lft || btm <= tp) return;
      for (int r = tp / CELL_SIZE; r <= (btm - 1) / CELL_SIZE; r++)
        for (int c = lft / CELL_SIZE; c <= (rgt - 1) / CELL_SIZE; c++)
          dirty_rows[r][c] = 1'b1;
    endfunction

    // One rectangle per horizontal run of dirty cells, row-major
    function void collect_runs(output out_item_t runs[$]);
      int w, h, cols, rows, c, first, rgt, btm;
      out_item_t run;
      runs = {};
      w    = width_px();
      h    = height_px();
      cols = (w + CELL_SIZE - 1) / CELL_SIZE;
      rows = (h + CELL_SIZE - 1) / CELL_SIZE;
      for (int r = 0; r < rows; r++) begin
        c = 0;
        while (c < cols) begin
          while (c < cols && !dirty_rows[r][c]) c++;
          if (c == cols) break;
          first = c;
          while (c < cols && dirty_rows[r][c]) c++;
          rgt = c * CELL_SIZE;
          btm = (r + 1) * CELL_SIZE;
          if (rgt > w) rgt = w;
          if (btm > h) btm = h;
          run            = '0;
          run.status     = ST_OK;
          run.has_rect   = 1'b1;
          run.out_x      = 8'(first * CELL_SIZE);
          run.out_y      = 8'(r * CELL_SIZE);
          run.out_width  = DIM_W'(rgt - first * CELL_SIZE);
          run.out_height = DIM_W'(btm - r * CELL_SIZE);
          runs.push_back(run);
        end
      end
    endfunction

    // Apply one accepted item and queue the results it owes
    function void take_command(in_item_t it);
      out_item_t   fresh [$];
      out_item_t   runs [$];
      out_item_t   one;
      int unsigned cap;
      one        = '0;
      one.status = ST_OK;
      one.last   = 1'b1;
      case (it.cmd)
        CMD_MARK: begin
          if (it.rect_width == '0 || it.rect_height == '0) one.status = ST_INVALID;
          else mark_area(it);
          fresh.push_back(one);
        end
        CMD_ALL: begin
          whole_screen = 1'b1;
          fresh.push_back(one);
        end
        CMD_CLEAR: begin
          wipe();
          fresh.push_back(one);
        end
        CMD_COLLECT: begin
          cap = capacity > RESULT_LIMIT ? RESULT_LIMIT : capacity;
          if (!any_dirty()) begin
            fresh.push_back(one);
          end else if (cap == 0) begin
            // damage is kept for a later collect
            one.status = ST_CAP;
            fresh.push_back(one);
          end else begin
            collect_runs(runs);
            if (whole_screen || runs.size() > cap) begin
              one.has_rect   = 1'b1;
              one.out_width  = DIM_W'(width_px());
              one.out_height = DIM_W'(height_px());
              one.full_res   = 1'b1;
              fresh.push_back(one);
            end else begin
              runs[runs.size() - 1].last = 1'b1;
              fresh = runs;
            end
            wipe();
          end
        end
        default: ;
      endcase
      foreach (fresh[k]) begin
        fresh[k].pending = any_dirty();
        expected_reports.push_back(fresh[k]);
      end
    endfunction

    task report(string what);
      errors++;
      // keep the log short when a broken block floods mismatches
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0d want %0d", seen, name, got, want));
    endtask

    task check_report(out_item_t got);
      out_item_t want;
      seen++;
      if (expected_reports.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", seen));
        return;
      end
      want = expected_reports.pop_front();
      compare_field("status", got.status, want.status);
      compare_field("has_rect", got.has_rect, want.has_rect);
      compare_field("out_x", got.out_x, want.out_x);
      compare_field("out_y", got.out_y, want.out_y);
      compare_field("out_width", got.out_width, want.out_width);
      compare_field("out_height", got.out_height, want.out_height);
      compare_field("full_res", got.full_res, want.full_res);
      compare_field("pending", got.pending, want.pending);
      compare_field("last", got.last, want.last);
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [DIM_W-1:0] cfg_data;

  damage_ledger ledger = new();
  bit           sender_idle = 1'b1;
  bit           sink_idle = 1'b1;
  int           sink_wait = 0;

  tile_damage_tracker_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Watch all three channels and drive the result-side stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) ledger.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) ledger.take_command(in_item);
      if (out_valid && !out_stall) begin
        ledger.check_report(out_item);
        sink_wait = sink_idle ? $urandom_range(0, 14) : 0;
      end
    end
    if (sink_wait > 0) begin
      out_stall <= 1'b1;
      sink_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_item_t rect_cmd(logic [1:0] cmd, int x, int y, int w, int h);
    in_item_t it;
    it.cmd         = cmd;
    it.rect_x      = 16'(x);
    it.rect_y      = 16'(y);
    it.rect_width  = 16'(w);
    it.rect_height = 16'(h);
    return it;
  endfunction

  // Mostly in-scene marks with regular collects, some raw noise and zero sizes
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    pick           = $urandom_range(0, 99);
    it.rect_x      = 16'($urandom);
    it.rect_y      = 16'($urandom);
    it.rect_width  = 16'($urandom);
    it.rect_height = 16'($urandom);
    if (pick < 62) begin
      it.cmd = CMD_MARK;
      if (pick < 52) begin
        it.rect_x = 16'(int'($urandom_range(0, ledger.width_px() + 32)) - 16);
        it.rect_y = 16'(int'($urandom_range(0, ledger.height_px() + 32)) - 16);
        it.rect_width  = 16'($urandom_range(0, 5) == 0 ? $urandom_range(1, 320)
                                                     : $urandom_range(1, 40));
        it.rect_height = 16'($urandom_range(0, 5) == 0 ? $urandom_range(1, 320)
                                                     : $urandom_range(1, 40));
      end else if (pick >= 58) begin
        if ($urandom_range(0, 1) == 0) it.rect_width = '0;
        else it.rect_height = '0;
      end
    end else if (pick < 66) begin
      it.cmd = CMD_ALL;
    end else if (pick < 72) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = CMD_COLLECT;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = sender_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Let every owed result drain, then pause so the block can go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(rect_cmd(CMD_COLLECT, 0, 0, 0, 0));
    send_item(rect_cmd(CMD_MARK, 0, 0, 0, 5));
    send_item(rect_cmd(CMD_MARK, 0, 0, 7, 0));
    send_item(rect_cmd(CMD_MARK, 300, 10, 10, 10));
    send_item(rect_cmd(CMD_MARK, -32768, -32768, 100, 100));
    send_item(rect_cmd(CMD_MARK, 32767, 32767, 65535, 65535));
    send_item(rect_cmd(CMD_MARK, -20, -20, 40, 40));
    send_item(rect_cmd(CMD_MARK, 255, 255, 1, 1));
    send_item(rect_cmd(CMD_MARK, 100, 50, 30, 1));
    send_item(rect_cmd(CMD_COLLECT, 0, 0, 0, 0));
    // whole grid dirty: one run per row
    send_item(rect_cmd(CMD_MARK, -32768, -32768, 65535, 65535));
    send_item(rect_cmd(CMD_COLLECT, 0, 0, 0, 0));
    send_item(rect_cmd(CMD_ALL, 0, 0, 0, 0));
    send_item(rect_cmd(CMD_COLLECT, 0, 0, 0, 0));
    send_item(rect_cmd(CMD_MARK, 16, 16, 16, 16));
    send_item(rect_cmd(CMD_CLEAR, 0, 0, 0, 0));
    send_item(rect_cmd(CMD_COLLECT, 0, 0, 0, 0));
    send_item(rect_cmd(CMD_MARK, 0, 0, 1, 1));
    send_item(rect_cmd(CMD_ALL, 0, 0, 0, 0));
    send_item(rect_cmd(CMD_COLLECT, 0, 0, 0, 0));
    send_item(rect_cmd(CMD_MARK, -1, -1, 2, 2));
    send_item(rect_cmd(CMD_MARK, 8, 200, 65535, 3));
    send_item(rect_cmd(CMD_COLLECT, 0, 0, 0, 0));
  endtask

  // Register settings per phase: fixed ones with extremes first, then random ones
  logic [DIM_W-1:0] phase_w [FIXED_PHASES] = '{9'd0, 9'd40, 9'd511, 9'd256, 9'd17, 9'd160};
  logic [DIM_W-1:0] phase_h [FIXED_PHASES] = '{9'd511, 9'd23, 9'd1, 9'd256, 9'd200, 9'd96};
  logic [DIM_W-1:0] phase_cap [FIXED_PHASES] = '{9'h1FF, 9'd3, 9'd0, 9'd64, 9'd1, 9'd8};

  initial begin
    logic [DIM_W-1:0] w, h, cap;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SCENE_W;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    settle();
    for (int p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
      if (p < FIXED_PHASES) begin
        w   = phase_w[p];
        h   = phase_h[p];
        cap = phase_cap[p];
      end else begin
        w   = DIM_W'($urandom_range(0, 511));
        h   = DIM_W'($urandom_range(0, 511));
        cap = DIM_W'($urandom_range(0, 70));
      end
      write_reg(CFG_SCENE_W, w);
      write_reg(CFG_SCENE_H, h);
      write_reg(CFG_CAPACITY, cap);
      if (p == 0) write_reg(CFG_UNUSED, DIM_W'($urandom));
      repeat (ITEMS_PER_PHASE) begin
        // switch between idling and full-rate stretches now and then
        if ($urandom_range(0, 15) == 0) begin
          sender_idle = $urandom_range(0, 2) != 0;
          sink_idle   = $urandom_range(0, 2) != 0;
        end
        send_item(random_item());
      end
      settle();
    end
    repeat (40) @(posedge clk);
    if (ledger.errors == 0 && ledger.expected_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
